// ----- rtl/core/rectilinear_grid_edge_locator_top_macros.svh -----
// assertion macros for the rectilinear grid edge locator
// used by the top level only
`ifndef RECTILINEAR_GRID_EDGE_LOCATOR_TOP_MACROS_SVH
`define RECTILINEAR_GRID_EDGE_LOCATOR_TOP_MACROS_SVH
// property checked at each rising clock edge while reset is released
`define RGEL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// signal keeps its value in the cycle after the condition
`define RGEL_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);
`endif

// ----- rtl/core/rgel_pkg.sv -----
// package for the rectilinear grid edge locator
// types, constants and sizes used by the top level
package rgel_pkg;
  localparam int unsigned MaxCoords = 64;
  localparam int unsigned SlotW = $clog2(MaxCoords);
  localparam int unsigned AddrW = SlotW + 2;
  localparam int unsigned FracBits = 15;
  localparam int unsigned WeightW = FracBits + 1;
  localparam int unsigned IdxW = 18;
  localparam int unsigned SizeW = 7;

  typedef enum logic [0:0] {OP_LOAD = 1'b0, OP_LOCATE = 1'b1} opcode_e;
  typedef enum logic [2:0] {
    REG_SIZE_X = 3'd0, REG_SIZE_Y = 3'd1, REG_SIZE_Z = 3'd2,
    REG_ASC = 3'd3, REG_EDGE = 3'd4
  } reg_e;
  typedef enum logic [3:0] {
    ST_IDLE, ST_AXIS, ST_PROBE, ST_WAIT, ST_CMP, ST_RD0, ST_RD1, ST_RDW,
    ST_LO, ST_DIV, ST_IDX, ST_WMUL, ST_OUT
  } state_e;
endpackage

// ----- rtl/core/rgel_ram.sv -----
// generic single port ram with registered read
// no dependencies
module rgel_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  // read one address per cycle, and write it when we_i is set
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- rtl/core/rectilinear_grid_edge_locator_top.sv -----
// top level of the rectilinear grid edge locator
// uses rgel_pkg, rgel_ram and the assertion macro header
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata, tuser = opcode
// m_axis    out  m_axis_tvalid/tready    tdata, tuser = found
// cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a load is written to the table as it is accepted; a locate runs s = floor(log2(n))+1
// search steps per axis (7 for 64 entries); a flat axis skips the search and a miss
// ends the item early. a locate is sequenced through the single table port, one 48-bit
// restoring divider (one bit a cycle) and one 16x16 multiplier shared by the four
// weights.
// reset returns control, the config registers and the output register to their defaults;
// a result waits in the output register; a finished locate stalls until it is free.
`include "rectilinear_grid_edge_locator_top_macros.svh"
module rectilinear_grid_edge_locator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // axis_select[1:0], table_slot[7:2], load_value[39:8], pos_x[71:40],
  // pos_y[103:72], pos_z[135:104]
  input  logic [135:0] s_axis_tdata,
  // opcode[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cell_index[17:0], point_index_0..3[89:18], weight_0..3[153:90]
  output logic [159:0] m_axis_tdata,
  // found[0]
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import rgel_pkg::*;

  localparam int unsigned DivW = 32 + FracBits + 1;
  localparam int unsigned CntW = $clog2(DivW + 1);
  localparam logic [WeightW-1:0] One = WeightW'(1) << FracBits;

  state_e state_q, state_d;
  logic [SizeW-1:0] size_q [3];
  logic [2:0] asc_q;
  logic [1:0] edge_q;

  // query and per-axis results
  logic signed [31:0] pos_q [3];
  logic [1:0] ax_q;
  logic [SlotW:0] first_q, count_q;
  logic [SlotW-1:0] idx_q [3];
  logic [WeightW-1:0] frac_q [3];
  logic signed [32:0] num_q, den_q;
  logic signed [31:0] c0_q;
  logic [DivW-1:0] rem_q, quo_q;
  logic [32:0] dvs_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0] wsel_q;
  logic [31:0] prod_q;
  logic [IdxW-1:0] cell_q, base_q, o1_q, o2_q, dxy_q;
  logic [WeightW-1:0] w_q [4];
  logic found_q, out_v_q;
  logic [159:0] out_data_q;
  logic out_found_q;

  // table memory
  logic we;
  logic [AddrW-1:0] addr;
  logic [31:0] rdata;
  rgel_ram #(.Width(32), .Depth(3 * MaxCoords)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(s_axis_tdata[39:8]), .rdata_o(rdata)
  );

  logic [SizeW-1:0] n;
  logic [SlotW:0] step;
  logic asc;
  logic signed [31:0] p;
  logic pred;
  logic [SizeW-1:0] neff [3];
  logic [1:0] dsel, d1, d2;
  logic [WeightW-1:0] ma, mb;
  logic rd_miss, div_done, out_load;
  state_e next_ax;
  logic [159:0] res_data;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (size_q[a] == '0) neff[a] = SizeW'(1);
      else if (size_q[a] > SizeW'(MaxCoords)) neff[a] = SizeW'(MaxCoords);
      else neff[a] = size_q[a];
    end
  end
  assign n = neff[ax_q];
  assign step = count_q >> 1;
  assign asc = asc_q[ax_q];
  assign p = pos_q[ax_q];
  assign pred = asc ? ($signed(rdata) < p) : ($signed(rdata) > p);
  assign dsel = (edge_q == 2'd1) ? 2'd1 : (edge_q == 2'd2) ? 2'd2 : 2'd0;
  assign d1 = (dsel == 2'd2) ? 2'd0 : dsel + 2'd1;
  assign d2 = (dsel == 2'd0) ? 2'd2 : dsel - 2'd1;

  // first-entry check: flat axis must match, else point below the table
  assign rd_miss = (n == SizeW'(1)) ? ($signed(rdata) != p)
                 : (asc ? (p < $signed(rdata)) : (p > $signed(rdata)));
  assign div_done = (cnt_q > CntW'(DivW + 1));
  assign next_ax = (ax_q == 2'd2) ? ST_IDX : ST_AXIS;
  assign out_load = (state_q == ST_OUT) && (!out_v_q || m_axis_tready);

  // multiplier operands by weight number
  always_comb begin
    unique case (wsel_q)
      2'd0: begin ma = One - frac_q[d1]; mb = One - frac_q[d2]; end
      2'd1: begin ma = frac_q[d1]; mb = One - frac_q[d2]; end
      2'd2: begin ma = frac_q[d1]; mb = frac_q[d2]; end
      default: begin ma = One - frac_q[d1]; mb = frac_q[d2]; end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // next state and memory address
  always_comb begin
    state_d = state_q;
    we = 1'b0;
    addr = {ax_q, first_q[SlotW-1:0] + step[SlotW-1:0]};
    unique case (state_q)
      ST_IDLE: begin
        addr = {s_axis_tdata[1:0], s_axis_tdata[7:2]};
        if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tuser == OP_LOCATE) state_d = ST_AXIS;
          else we = (s_axis_tdata[1:0] != 2'd3);
        end
      end
      ST_AXIS: state_d = (n == SizeW'(1)) ? ST_RD0 : ST_PROBE;
      ST_PROBE: begin
        // search done once the range is empty
        if (count_q != '0) state_d = ST_WAIT;
        else if (first_q >= (SlotW+1)'(n)) state_d = ST_OUT;
        else if (first_q == '0) state_d = ST_RD0;
        else state_d = ST_LO;
      end
      ST_WAIT: state_d = ST_CMP;
      ST_CMP: state_d = ST_PROBE;
      ST_RD0: begin addr = {ax_q, {SlotW{1'b0}}}; state_d = ST_RDW; end
      ST_RDW: begin
        if (rd_miss) state_d = ST_OUT;
        else if (n == SizeW'(1)) state_d = next_ax;
        else state_d = ST_LO;
      end
      ST_LO: begin addr = {ax_q, first_q[SlotW-1:0]}; state_d = ST_RD1; end
      ST_RD1: begin addr = {ax_q, first_q[SlotW-1:0] + 1'b1}; state_d = ST_DIV; end
      ST_DIV: if (div_done) state_d = next_ax;
      ST_IDX: state_d = ST_WMUL;
      ST_WMUL: if (cnt_q == CntW'(7)) state_d = ST_OUT;
      ST_OUT: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // result fields as packed on the output
  assign res_data = found_q ? {6'd0, w_q[3], w_q[2], w_q[1], w_q[0],
      base_q + o2_q, base_q + o1_q + o2_q, base_q + o1_q, base_q, cell_q} : '0;

  // sequencer datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q <= '{SizeW'(1), SizeW'(1), SizeW'(1)};
      asc_q <= 3'b111;
      edge_q <= 2'd0;
      out_v_q <= 1'b0;
      out_data_q <= '0;
      out_found_q <= 1'b0;
      found_q <= 1'b0;
      ax_q <= 2'd0;
      first_q <= '0;
      count_q <= '0;
      cnt_q <= '0;
      wsel_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SIZE_X: size_q[0] <= cfg_data_i[SizeW-1:0];
          REG_SIZE_Y: size_q[1] <= cfg_data_i[SizeW-1:0];
          REG_SIZE_Z: size_q[2] <= cfg_data_i[SizeW-1:0];
          REG_ASC: asc_q <= cfg_data_i[2:0];
          REG_EDGE: edge_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      // output register
      if (out_load) begin
        out_v_q <= 1'b1;
        out_data_q <= res_data;
        out_found_q <= found_q;
      end else if (m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOCATE) begin
          pos_q[0] <= s_axis_tdata[71:40];
          pos_q[1] <= s_axis_tdata[103:72];
          pos_q[2] <= s_axis_tdata[135:104];
          ax_q <= 2'd0;
          found_q <= 1'b0;
        end
        ST_AXIS: begin first_q <= '0; count_q <= (SlotW+1)'(n); end
        ST_PROBE: if (count_q == '0 && first_q != '0) first_q <= first_q - 1'b1;
        ST_CMP: if (pred) begin
          first_q <= first_q + step + 1'b1;
          count_q <= count_q - step - 1'b1;
        end else count_q <= step;
        ST_RDW: if (!rd_miss && n == SizeW'(1)) begin
          idx_q[ax_q] <= '0;
          frac_q[ax_q] <= '0;
          ax_q <= ax_q + 1'b1;
        end
        ST_RD1: begin
          c0_q <= rdata;
          num_q <= 33'(p) - 33'($signed(rdata));
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            den_q <= 33'($signed(rdata)) - 33'(c0_q);
            dvs_q <= '0;
            cnt_q <= CntW'(1);
          end else if (cnt_q == CntW'(1)) begin
            rem_q <= '0;
            quo_q <= DivW'(num_q[32] ? -num_q : num_q) << FracBits;
            dvs_q <= den_q[32] ? 33'(-den_q) : 33'(den_q);
            cnt_q <= CntW'(2);
          end else if (!div_done) begin
            // restoring divide, one bit a cycle
            if ({rem_q[DivW-2:0], quo_q[DivW-1]} >= DivW'(dvs_q)) begin
              rem_q <= {rem_q[DivW-2:0], quo_q[DivW-1]} - DivW'(dvs_q);
              quo_q <= {quo_q[DivW-2:0], 1'b1};
            end else begin
              rem_q <= {rem_q[DivW-2:0], quo_q[DivW-1]};
              quo_q <= {quo_q[DivW-2:0], 1'b0};
            end
            cnt_q <= cnt_q + 1'b1;
          end else begin
            idx_q[ax_q] <= first_q[SlotW-1:0];
            if (num_q == '0 || den_q == '0 || num_q[32] != den_q[32])
              frac_q[ax_q] <= '0;
            else if (quo_q > DivW'(One)) frac_q[ax_q] <= One;
            else frac_q[ax_q] <= quo_q[WeightW-1:0];
            cnt_q <= '0;
            ax_q <= ax_q + 1'b1;
          end
        end
        ST_IDX: begin
          dxy_q <= IdxW'(neff[0]) * IdxW'(neff[1]);
          base_q <= (IdxW'(idx_q[2]) * IdxW'(neff[1]) + IdxW'(idx_q[1]));
          cell_q <= (IdxW'(idx_q[2]) * IdxW'(neff[1] - 1'b1) + IdxW'(idx_q[1]));
          wsel_q <= '0;
          cnt_q <= '0;
        end
        ST_WMUL: begin
          cnt_q <= cnt_q + 1'b1;
          unique case (cnt_q)
            CntW'(0): begin
              base_q <= base_q * IdxW'(neff[0]) + IdxW'(idx_q[0]);
              cell_q <= cell_q * IdxW'(neff[0] - 1'b1) + IdxW'(idx_q[0]);
              prod_q <= ma * mb;
            end
            CntW'(1), CntW'(3), CntW'(5), CntW'(7): begin
              w_q[wsel_q] <= WeightW'((prod_q + (32'd1 << (FracBits - 1))) >> FracBits);
              wsel_q <= wsel_q + 1'b1;
              if (cnt_q == CntW'(7)) found_q <= 1'b1;
            end
            default: prod_q <= ma * mb;
          endcase
          o1_q <= (idx_q[d1] == '0) ? '0 : (d1 == 2'd0) ? IdxW'(1)
                : (d1 == 2'd1) ? IdxW'(neff[0]) : dxy_q;
          o2_q <= (idx_q[d2] == '0) ? '0 : (d2 == 2'd0) ? IdxW'(1)
                : (d2 == 2'd1) ? IdxW'(neff[0]) : dxy_q;
        end
        ST_OUT: cnt_q <= '0;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser = out_found_q;
  assign m_axis_tdata = out_data_q;

  `RGEL_ASSERT(a_no_accept_busy, (state_q != ST_IDLE) |-> !s_axis_tready, "ready while busy")
  `RGEL_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped")
  `RGEL_ASSERT_HOLD(a_out_stable, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "result changed")
  `RGEL_ASSERT(a_ax_range, (state_q != ST_IDLE) |-> (ax_q != 2'd3 || state_q == ST_IDX ||
      state_q == ST_WMUL || state_q == ST_OUT), "axis out of range")
endmodule
